/* rtl/mat4_multiply_accumulate_defines.svh */
// Assertion macros for the 4x4 float32 matrix multiply-accumulate block.
// Included by the RTL files that carry concurrent assertions; needs aclk and aresetn in scope.
`ifndef MAT4_MULTIPLY_ACCUMULATE_DEFINES_SVH
`define MAT4_MULTIPLY_ACCUMULATE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define M4MAC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define M4MAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/m4mac_pkg.sv */
// Shared types and constants for the 4x4 float32 matrix multiply-accumulate block.
// No dependencies; used by m4mac_fpu, mat4_multiply_accumulate and the testbench.
`default_nettype none

package m4mac_pkg;

    localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    localparam logic [1:0] OP_WRITE_CUR = 2'd0;
    localparam logic [1:0] OP_WRITE_OPD = 2'd1;
    localparam logic [1:0] OP_MULTIPLY  = 2'd2;
    localparam logic [1:0] OP_IDENTITY  = 2'd3;

    // request to the shared float unit
    typedef struct packed {
        logic        start;
        logic        is_add;
        logic [31:0] a;
        logic [31:0] b;
    } fpu_req_t;

    // element of the identity matrix at index {col,row}
    function automatic logic [31:0] identity_elem(input logic [3:0] idx);
        return (idx[3:2] == idx[1:0]) ? ONE_BITS : 32'h0;
    endfunction

endpackage

`default_nettype wire

/* rtl/m4mac_fpu.sv */
// Shared float32 multiply/add unit, round-to-nearest-even, subnormals kept, result registered.
// Depends on m4mac_pkg for the request struct and the canonical NaN.
`default_nettype none

module m4mac_fpu (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire m4mac_pkg::fpu_req_t req,
    output logic                    done,
    output logic [31:0]             result
);
    import m4mac_pkg::*;

    // stage 1: unpacked operands, then product or aligned sum
    logic        sa, sb;
    logic [7:0]  ea, eb, exa, exb;
    logic [23:0] sig_a, sig_b;
    logic        zero_a, zero_b, inf_a, inf_b, nan_a, nan_b;
    logic [47:0] prod;
    logic        a_big;
    logic        sx, sy;
    logic [7:0]  exx, exy, dexp;
    logic [23:0] sigx, sigy;
    logic [49:0] xw, yw, ysh, yp, sum;
    logic        yst;

    logic        s1_spec, s1_sign;
    logic [31:0] s1_spec_val;
    logic [49:0] s1_w;
    logic signed [10:0] s1_base;

    logic        v1_reg, v2_reg;
    logic        spec_reg, sign_reg;
    logic [31:0] spec_val_reg;
    logic [49:0] w_reg;
    logic signed [10:0] base_reg;
    logic [31:0] result_reg;

    always_comb begin
        sa = req.a[31];
        sb = req.b[31];
        ea = req.a[30:23];
        eb = req.b[30:23];
        exa = (ea == 8'd0) ? 8'd1 : ea;
        exb = (eb == 8'd0) ? 8'd1 : eb;
        sig_a = {ea != 8'd0, req.a[22:0]};
        sig_b = {eb != 8'd0, req.b[22:0]};
        zero_a = (req.a[30:0] == 31'd0);
        zero_b = (req.b[30:0] == 31'd0);
        inf_a = (ea == 8'hFF) && (req.a[22:0] == 23'd0);
        inf_b = (eb == 8'hFF) && (req.b[22:0] == 23'd0);
        nan_a = (ea == 8'hFF) && (req.a[22:0] != 23'd0);
        nan_b = (eb == 8'hFF) && (req.b[22:0] != 23'd0);

        prod = sig_a * sig_b;

        // order by magnitude, larger one leads
        a_big = (req.a[30:0] >= req.b[30:0]);
        sx   = a_big ? sa : sb;
        sy   = a_big ? sb : sa;
        exx  = a_big ? exa : exb;
        exy  = a_big ? exb : exa;
        sigx = a_big ? sig_a : sig_b;
        sigy = a_big ? sig_b : sig_a;
        dexp = exx - exy;
        xw = {1'b0, sigx, 25'd0};
        yw = {1'b0, sigy, 25'd0};
        if (dexp >= 8'd50) begin
            ysh = 50'd0;
            yst = (yw != 50'd0);
        end else begin
            ysh = yw >> dexp[5:0];
            yst = ((ysh << dexp[5:0]) != yw);
        end
        yp  = ysh | {49'd0, yst};
        sum = (sx != sy) ? (xw - yp) : (xw + yp);

        s1_spec = 1'b0;
        s1_spec_val = CANON_NAN;
        if (req.is_add) begin
            s1_w    = sum;
            s1_base = $signed({3'd0, exx}) - 11'sd48;
            s1_sign = (sum == 50'd0) ? (sx & sy) : sx;
            if (nan_a || nan_b || (inf_a && inf_b && (sa != sb))) begin
                s1_spec = 1'b1;
            end else if (inf_a) begin
                s1_spec = 1'b1;
                s1_spec_val = {sa, 8'hFF, 23'd0};
            end else if (inf_b) begin
                s1_spec = 1'b1;
                s1_spec_val = {sb, 8'hFF, 23'd0};
            end
        end else begin
            s1_w    = {2'd0, prod};
            s1_base = $signed({3'd0, exa}) + $signed({3'd0, exb}) - 11'sd173;
            s1_sign = sa ^ sb;
            if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) begin
                s1_spec = 1'b1;
            end else if (inf_a || inf_b) begin
                s1_spec = 1'b1;
                s1_spec_val = {sa ^ sb, 8'hFF, 23'd0};
            end else if (zero_a || zero_b) begin
                s1_spec = 1'b1;
                s1_spec_val = {sa ^ sb, 31'd0};
            end
        end
    end

    // stage 2: normalize, shift into the subnormal range if needed, round
    logic [5:0]  lead;
    logic [49:0] norm;
    logic [47:0] nw, nw2;
    logic signed [10:0] re, shr;
    logic [7:0]  expf;
    logic        rnd_inc;
    logic [31:0] s2_val;

    always_comb begin
        lead = 6'd0;
        for (int i = 0; i < 50; i++) begin
            if (w_reg[i]) begin
                lead = 6'(i);
            end
        end
        norm = w_reg << (6'd49 - lead);
        nw   = {norm[49:3], |norm[2:0]};
        re   = base_reg + $signed({5'd0, lead});
        shr  = 11'sd1 - re;
        expf = 8'd0;
        nw2  = nw;
        if (re < 11'sd1) begin
            if (shr >= 11'sd48) begin
                nw2 = {47'd0, |nw};
            end else begin
                nw2 = (nw >> shr[5:0]) | {47'd0, ((nw >> shr[5:0]) << shr[5:0]) != nw};
            end
        end else begin
            expf = re[7:0];
        end
        rnd_inc = nw2[23] && ((|nw2[22:0]) || nw2[24]);
        if (spec_reg) begin
            s2_val = spec_val_reg;
        end else if (w_reg == 50'd0) begin
            s2_val = {sign_reg, 31'd0};
        end else if (re >= 11'sd255) begin
            s2_val = {sign_reg, 8'hFF, 23'd0};
        end else begin
            s2_val = {sign_reg, {expf, nw2[46:24]} + {30'd0, rnd_inc}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= req.start;
            v2_reg <= v1_reg;
        end
        spec_reg     <= s1_spec;
        spec_val_reg <= s1_spec_val;
        sign_reg     <= s1_sign;
        w_reg        <= s1_w;
        base_reg     <= s1_base;
        result_reg   <= s2_val;
    end

    assign done   = v2_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

/* rtl/mat4_multiply_accumulate.sv */
// Top level of the 4x4 float32 matrix multiply-accumulate block: matrix storage and sequencer.
// Depends on m4mac_pkg, m4mac_fpu and mat4_multiply_accumulate_defines.svh.
//
// Holds a current and an operand 4x4 float32 matrix (column-major, both reset to identity).
// Write and identity items are applied when accepted. A multiply item replaces the current matrix with
// current x operand and emits the 16 new elements column by column, the last with m_tlast.
// Each element is four multiply-adds through one shared float unit, each a multiply and then an add
// of the product into the accumulator; s_tready stays low for the whole multiply, including any
// output stall. NaN results come out as 0x7FC00000.
`default_nettype none

`include "mat4_multiply_accumulate_defines.svh"

module mat4_multiply_accumulate (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // col[1:0], row[3:2], value[35:4], zero pad
    input  wire logic [1:0]  s_tuser,   // op[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // out_col[1:0], out_row[3:2], out_value[35:4], zero pad
    output logic             m_tlast
);
    import m4mac_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FETCH = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_MWAIT = 3'd3;
    localparam logic [2:0] ST_ADD   = 3'd4;
    localparam logic [2:0] ST_AWAIT = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    logic [2:0]  state_reg;
    logic [3:0]  idx_reg;
    logic [1:0]  k_reg;
    logic [31:0] a_reg, b_reg, p_reg, acc_reg, out_value_reg;
    logic [31:0] cur_reg  [16];
    logic [31:0] opd_reg  [16];
    logic [31:0] prod_reg [16];

    fpu_req_t    fpu_req;
    logic        fpu_done;
    logic [31:0] fpu_result;
    logic        s_acc, m_acc;
    logic [3:0]  wr_idx;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    // storage index is {col,row}
    assign wr_idx = {s_tdata[1:0], s_tdata[3:2]};

    always_comb begin
        fpu_req.start  = (state_reg == ST_MUL) || (state_reg == ST_ADD);
        fpu_req.is_add = (state_reg == ST_ADD);
        fpu_req.a      = (state_reg == ST_ADD) ? acc_reg : a_reg;
        fpu_req.b      = (state_reg == ST_ADD) ? p_reg : b_reg;
    end

    m4mac_fpu u_fpu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (fpu_req),
        .done    (fpu_done),
        .result  (fpu_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= 4'd0;
            k_reg     <= 2'd0;
            for (int i = 0; i < 16; i++) begin
                cur_reg[i] <= identity_elem(4'(i));
                opd_reg[i] <= identity_elem(4'(i));
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        case (s_tuser)
                            OP_WRITE_CUR: cur_reg[wr_idx] <= s_tdata[35:4];
                            OP_WRITE_OPD: opd_reg[wr_idx] <= s_tdata[35:4];
                            OP_IDENTITY: begin
                                for (int i = 0; i < 16; i++) begin
                                    cur_reg[i] <= identity_elem(4'(i));
                                end
                            end
                            default: begin
                                idx_reg   <= 4'd0;
                                k_reg     <= 2'd0;
                                state_reg <= ST_FETCH;
                            end
                        endcase
                    end
                end
                ST_FETCH: begin
                    // current(k,row) and operand(col,k)
                    a_reg <= cur_reg[{k_reg, idx_reg[1:0]}];
                    b_reg <= opd_reg[{idx_reg[3:2], k_reg}];
                    if (k_reg == 2'd0) begin
                        acc_reg <= 32'd0;
                    end
                    state_reg <= ST_MUL;
                end
                ST_MUL: state_reg <= ST_MWAIT;
                ST_MWAIT: begin
                    if (fpu_done) begin
                        p_reg     <= fpu_result;
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD: state_reg <= ST_AWAIT;
                ST_AWAIT: begin
                    if (fpu_done) begin
                        acc_reg <= fpu_result;
                        if (k_reg == 2'd3) begin
                            out_value_reg     <= fpu_result;
                            prod_reg[idx_reg] <= fpu_result;
                            state_reg         <= ST_EMIT;
                        end else begin
                            state_reg <= ST_FETCH;
                        end
                        k_reg <= k_reg + 2'd1;
                    end
                end
                ST_EMIT: begin
                    if (m_acc) begin
                        if (idx_reg == 4'd15) begin
                            for (int i = 0; i < 16; i++) begin
                                cur_reg[i] <= prod_reg[i];
                            end
                            state_reg <= ST_IDLE;
                        end else begin
                            state_reg <= ST_FETCH;
                        end
                        idx_reg <= idx_reg + 4'd1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tlast  = (idx_reg == 4'd15);
    assign m_tdata  = {4'd0, out_value_reg, idx_reg[1:0], idx_reg[3:2]};

    `M4MAC_ASSERT_SAME(a_no_overlap, s_tready, !m_tvalid, "input ready while a result is pending")
    `M4MAC_ASSERT_SAME(a_fpu_done_wait, fpu_done,
        (state_reg == ST_MWAIT) || (state_reg == ST_AWAIT), "float unit result outside a wait")
    `M4MAC_ASSERT_NEXT(a_last_to_idle, m_acc && m_tlast, s_tready, "not idle after last item")
    `M4MAC_ASSERT_NEXT(a_emit_after_mac, m_acc && !m_tlast,
        (state_reg == ST_FETCH) && (k_reg == 2'd0), "next element does not start at k zero")

endmodule

`default_nettype wire

/* dv/tb.sv */
// Testbench for the 4x4 float32 matrix multiply-accumulate block, with its own
// float predictor and an in-order scoreboard. Depends on m4mac_pkg and the block RTL.
`timescale 1ns / 100ps

module tb;
    import m4mac_pkg::*;

    typedef struct {
        logic [1:0]  col;
        logic [1:0]  row;
        logic [31:0] value;
        logic        last;
    } elem_t;

    class product_scoreboard;
        logic [31:0] cur_mat[16];
        logic [31:0] opd_mat[16];
        elem_t       pending_elems[$];
        int          errors;

        function new();
            for (int i = 0; i < 16; i++) begin
                cur_mat[i] = (i % 5 == 0) ? ONE_BITS : 32'h0;
                opd_mat[i] = cur_mat[i];
            end
            errors = 0;
        endfunction

        // binary32 to binary64, exact
        function real to_double(logic [31:0] b);
            logic [63:0] d;
            logic [22:0] m;
            int          p;
            d = {b[31], 63'h0};
            m = b[22:0];
            if (b[30:23] == 8'hFF) begin
                d[62:52] = 11'h7FF;
                d[51:29] = m;
            end else if (b[30:23] != 0) begin
                d[62:52] = 11'(b[30:23] - 127 + 1023);
                d[51:29] = m;
            end else if (m != 0) begin
                p = 22;
                while (!m[p]) p--;
                d[62:52] = 11'(p - 149 + 1023);
                d[51:0] = (64'(m) << (52 - p)) & 64'h000F_FFFF_FFFF_FFFF;
            end
            return $bitstoreal(d);
        endfunction

        // binary64 to binary32, round to nearest even, subnormals kept
        function logic [31:0] to_single(real x);
            logic [63:0] d, sig, q, rem, half;
            int          e, sh;
            logic        s;
            d = $realtobits(x);
            s = d[63];
            if (d[62:52] == 11'h7FF)
                return (d[51:0] != 0) ? CANON_NAN : {s, 8'hFF, 23'h0};
            if (d[62:52] == 0)
                return {s, 31'h0};
            e = int'(d[62:52]) - 1023;
            if (e > 127)
                return {s, 8'hFF, 23'h0};
            sig = {12'h001, d[51:0]};
            sh = (e >= -126) ? 29 : 29 + (-126 - e);
            if (sh > 55) sh = 55;
            q = sig >> sh;
            rem = sig & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0])) q++;
            if (e < -126)
                return {s, 31'(q)};
            if (q[24]) begin
                q = q >> 1;
                e++;
            end
            if (e > 127)
                return {s, 8'hFF, 23'h0};
            return {s, 8'(e + 127), q[22:0]};
        endfunction

        function void note_item(logic [1:0] op, logic [1:0] col, logic [1:0] row,
                                logic [31:0] value);
            logic [31:0] prod[16];
            logic [31:0] acc, p;
            elem_t       el;
            case (op)
                OP_WRITE_CUR: cur_mat[{col, row}] = value;
                OP_WRITE_OPD: opd_mat[{col, row}] = value;
                OP_IDENTITY: begin
                    for (int i = 0; i < 16; i++)
                        cur_mat[i] = (i % 5 == 0) ? ONE_BITS : 32'h0;
                end
                default: begin
                    for (int c = 0; c < 4; c++) begin
                        for (int r = 0; r < 4; r++) begin
                            acc = 32'h0;
                            for (int k = 0; k < 4; k++) begin
                                p = to_single(to_double(cur_mat[k * 4 + r])
                                              * to_double(opd_mat[c * 4 + k]));
                                acc = to_single(to_double(acc) + to_double(p));
                            end
                            if (acc[30:23] == 8'hFF && acc[22:0] != 0) acc = CANON_NAN;
                            prod[c * 4 + r] = acc;
                        end
                    end
                    for (int n = 0; n < 16; n++) begin
                        cur_mat[n] = prod[n];
                        el.col = 2'(n / 4);
                        el.row = 2'(n % 4);
                        el.value = prod[n];
                        el.last = (n == 15);
                        pending_elems.push_back(el);
                    end
                end
            endcase
        endfunction

        function void check_result(logic [39:0] tdata, logic tlast);
            elem_t el;
            if (pending_elems.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result item: tdata=%h tlast=%b", tdata, tlast);
                return;
            end
            el = pending_elems.pop_front();
            if (tdata[1:0] !== el.col || tdata[3:2] !== el.row ||
                tdata[35:4] !== el.value || tlast !== el.last) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected col=%0d row=%0d value=%h last=%b, got col=%0d row=%0d value=%h last=%b",
                             el.col, el.row, el.value, el.last,
                             tdata[1:0], tdata[3:2], tdata[35:4], tlast);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    product_scoreboard sb = new();
    bit quiet_phase = 0;
    int results_seen = 0;

    mat4_multiply_accumulate dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tlast);
            results_seen++;
        end
    end

    // receiver: random stalls, plus one long hold-off once 40 results have been seen
    initial begin
        bit held_long;
        held_long = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held_long && results_seen >= 40) begin
                held_long = 1;
                m_tready <= 0;
                repeat (2000) @(negedge aclk);
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 15)) @(negedge aclk);
            end
            m_tready <= 1;
        end
    end

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(logic [1:0] op, logic [1:0] col, logic [1:0] row,
                             logic [31:0] value);
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {4'h0, value, row, col};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(op, col, row, value);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_float();
        case ($urandom_range(0, 15))
            0: return {$urandom_range(0, 1) == 1, 31'h0};
            1: return {$urandom_range(0, 1) == 1, 8'hFF, 23'h0};
            2: return {1'b0, 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
            3: return {1'b1, 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
            4: return {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom())};
            5: return $urandom();
            6: return {$urandom_range(0, 1) == 1, 8'(126 - $urandom_range(0, 1)), 23'($urandom())};
            default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(118, 136)),
                             23'($urandom())};
        endcase
    endfunction

    task automatic fill_matrix(logic [1:0] op);
        for (int i = 0; i < 16; i++)
            send_item(op, 2'(i / 4), 2'(i % 4), rand_float());
    endtask

    initial begin
        int    spent;
        logic [1:0] op;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: identity times identity, extremes, special values
        send_item(OP_MULTIPLY, 2'd3, 2'd3, 32'hFFFF_FFFF);
        send_item(OP_WRITE_CUR, 2'd0, 2'd0, 32'h7F7F_FFFF);
        send_item(OP_WRITE_OPD, 2'd0, 2'd0, 32'h7F7F_FFFF);
        send_item(OP_WRITE_CUR, 2'd3, 2'd3, 32'h0000_0001);
        send_item(OP_WRITE_OPD, 2'd3, 2'd3, 32'h3F00_0000);
        send_item(OP_WRITE_CUR, 2'd1, 2'd2, 32'hFFFF_FFFF);
        send_item(OP_WRITE_OPD, 2'd2, 2'd1, 32'h7F80_0001);
        send_item(OP_WRITE_CUR, 2'd2, 2'd1, 32'h8000_0000);
        send_item(OP_WRITE_OPD, 2'd1, 2'd1, 32'h7F80_0000);
        send_item(OP_MULTIPLY, 2'd0, 2'd0, 32'h0);
        send_item(OP_IDENTITY, 2'd2, 2'd1, 32'hFFFF_FFFF);
        send_item(OP_WRITE_CUR, 2'd3, 2'd0, 32'h0080_0000);
        send_item(OP_WRITE_OPD, 2'd0, 2'd3, 32'h3400_0000);
        send_item(OP_WRITE_CUR, 2'd0, 2'd1, 32'h007F_FFFF);
        send_item(OP_MULTIPLY, 2'd1, 2'd2, 32'h1234_5678);
        send_item(OP_MULTIPLY, 2'd0, 2'd0, 32'h0);

        // random: full loads of either matrix, or up to four noise writes and then a multiply
        spent = 0;
        while (spent < 400) begin
            if (spent > 330) quiet_phase = 1;
            case ($urandom_range(0, 9))
                0, 1: begin
                    send_item(OP_IDENTITY, 2'($urandom()), 2'($urandom()), $urandom());
                    fill_matrix(OP_WRITE_CUR);
                    spent += 17;
                end
                2, 3: begin
                    fill_matrix(OP_WRITE_OPD);
                    spent += 16;
                end
                default: begin
                    repeat ($urandom_range(0, 4)) begin
                        op = ($urandom_range(0, 1) == 1) ? OP_WRITE_CUR : OP_WRITE_OPD;
                        send_item(op, 2'($urandom()), 2'($urandom()), rand_float());
                        spent++;
                    end
                    if ($urandom_range(0, 5) == 0)
                        send_item(OP_IDENTITY, 2'($urandom()), 2'($urandom()), $urandom());
                    send_item(OP_MULTIPLY, 2'($urandom()), 2'($urandom()), $urandom());
                    spent += 2;
                end
            endcase
        end
        s_tvalid <= 0;

        while (sb.pending_elems.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
